// ===== src/dsed_pkg.sv =====
// ----------------------------------------------------------------------------
// dsed_pkg
// Shared types and constants of the DLE/STX/ETX receive deframer.
// ----------------------------------------------------------------------------
package dsed_pkg;

  // Framing characters
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_DLE = 8'h10;

  // Default payload limit per frame
  localparam int unsigned MAX_PAYLOAD_DEF = 256;

  // Width of the reported position field
  localparam int unsigned POS_W = 9;

  // Event codes of a result transfer
  typedef enum logic [2:0] {
    EV_CHAR     = 3'd0,
    EV_DONE     = 3'd1,
    EV_RESTART  = 3'd2,
    EV_ABANDON  = 3'd3,
    EV_NOBUF    = 3'd4,
    EV_OVERFLOW = 3'd5
  } event_t;

  // Received character transfer
  typedef struct packed {
    logic [7:0] rx_char;
    logic       buffer_ready;
  } in_t;

  // Result transfer
  typedef struct packed {
    logic [2:0]       event_res;
    logic [7:0]       char_value;
    logic [POS_W-1:0] position;
  } out_t;

endpackage

// ===== src/dsed_core.sv =====
// ----------------------------------------------------------------------------
// dsed_core
// Hunt state, payload count and buffer flag; decodes one character per
// accepted transfer into at most one result.
// ----------------------------------------------------------------------------
module dsed_core #(
  parameter int unsigned MAX_PAYLOAD = dsed_pkg::MAX_PAYLOAD_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  dsed_pkg::in_t in_data,
  output logic          res_valid,
  output dsed_pkg::out_t res_data
);
  import dsed_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PAYLOAD % (1 << POS_W));

  typedef enum logic [1:0] {
    ST_WAIT_DLE = 2'd0,
    ST_WAIT_STX = 2'd1,
    ST_DATA     = 2'd2,
    ST_DATA_DLE = 2'd3
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             held_r, held_nxt;
  logic [CNT_W+POS_W-1:0] count_ext;
  logic [POS_W-1:0] count_pos;
  logic             full;

  // Count as a position, wrapped to the field width
  assign count_ext = {{POS_W{1'b0}}, count_r};
  assign count_pos = count_ext[POS_W-1:0];
  assign full      = (count_r >= MAX_CNT);

  // Decode the character against the hunt state
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    held_nxt   = held_r;
    res_valid  = 1'b0;
    res_data   = '0;
    case (state_r)
      ST_WAIT_DLE: begin
        if (in_data.rx_char == CH_DLE) begin
          state_nxt = ST_WAIT_STX;
        end
      end
      ST_WAIT_STX: begin
        if (in_data.rx_char != CH_STX) begin
          state_nxt = ST_WAIT_DLE;
        end else if (held_r || in_data.buffer_ready) begin
          held_nxt  = 1'b1;
          count_nxt = '0;
          state_nxt = ST_DATA;
        end else begin
          state_nxt          = ST_WAIT_DLE;
          res_valid          = 1'b1;
          res_data.event_res = EV_NOBUF;
        end
      end
      ST_DATA, ST_DATA_DLE: begin
        state_nxt = ST_DATA;
        if (state_r == ST_DATA && in_data.rx_char == CH_DLE) begin
          state_nxt = ST_DATA_DLE;
        end else if (state_r == ST_DATA || in_data.rx_char == CH_DLE) begin
          // Payload character, plain or from a doubled DLE
          res_valid = 1'b1;
          if (full) begin
            state_nxt          = ST_WAIT_DLE;
            count_nxt          = '0;
            held_nxt           = 1'b0;
            res_data.event_res = EV_OVERFLOW;
            res_data.position  = MAX_POS;
          end else begin
            count_nxt           = count_r + 1'b1;
            res_data.event_res  = EV_CHAR;
            res_data.char_value = in_data.rx_char;
            res_data.position   = count_pos;
          end
        end else if (in_data.rx_char == CH_STX) begin
          count_nxt          = '0;
          res_valid          = 1'b1;
          res_data.event_res = EV_RESTART;
        end else begin
          // Close or abandon the frame and release the buffer
          state_nxt = ST_WAIT_DLE;
          held_nxt  = 1'b0;
          count_nxt = '0;
          res_valid = 1'b1;
          if (in_data.rx_char == CH_ETX) begin
            res_data.event_res = EV_DONE;
            res_data.position  = count_pos;
          end else begin
            res_data.event_res = EV_ABANDON;
          end
        end
      end
      default: begin
        state_nxt = ST_WAIT_DLE;
      end
    endcase
  end

  // Advance state on each accepted character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT_DLE;
      count_r <= '0;
      held_r  <= 1'b0;
    end else if (take) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ===== src/dsed_outreg.sv =====
// ----------------------------------------------------------------------------
// dsed_outreg
// Result register with valid/ready; takes a new result in the same cycle
// that the held one leaves.
// ----------------------------------------------------------------------------
module dsed_outreg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  dsed_pkg::out_t load_data,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output dsed_pkg::out_t out_data
);
  import dsed_pkg::*;

  logic valid_r;
  out_t data_r;

  // Free when empty or drained this cycle
  assign room      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= load;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (room && load) begin
      data_r <= load_data;
    end
  end

endmodule

// ===== src/dle_stx_etx_deframer.sv =====
// ----------------------------------------------------------------------------
// dle_stx_etx_deframer
// Receive deframer for DLE STX ... DLE ETX framing with DLE doubling.
// ----------------------------------------------------------------------------
// Takes one received character per clock cycle and gives at most one result
// per character, in the cycle after the character transfer, through a single
// result register. in_ready is high whenever that register is empty or is
// being drained in the same cycle, so the block sustains one character per
// cycle as long as the result side keeps up. Results: payload character with
// its index, frame done with its length, restart on DLE STX within a frame,
// abandon on any other DLE sequence, no buffer at frame start, and overflow
// when a frame exceeds MAX_PAYLOAD characters (the frame is discarded).
// Positions are reported modulo 512.
// ----------------------------------------------------------------------------
module dle_stx_etx_deframer #(
  parameter int unsigned MAX_PAYLOAD = dsed_pkg::MAX_PAYLOAD_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dsed_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dsed_pkg::out_t out_data
);
  import dsed_pkg::*;

  logic take;
  logic res_valid;
  out_t res_data;
  logic room;

  // Accept a character whenever the result register has room
  assign in_ready = room;
  assign take     = in_valid && room;

  dsed_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_data  (in_data),
    .res_valid(res_valid),
    .res_data (res_data)
  );

  dsed_outreg u_outreg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take && res_valid),
    .load_data(res_data),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== tb/tb_dle_stx_etx_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_dle_stx_etx_deframer
// Self-checking bench for the DLE/STX/ETX receive deframer.
// ----------------------------------------------------------------------------
// Characters are pushed through the valid/ready input while a local deframer
// model predicts the result of every accepted character. Each result transfer
// is compared field by field with the oldest prediction. Stimulus: a short
// directed sweep of the framing cases, frames at and past the payload limit,
// a long result-side stall, then random frames (mostly well formed, some
// broken, plus line noise) under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_dle_stx_etx_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import dsed_pkg::*;

  localparam int unsigned MAX_LEN = MAX_PAYLOAD_DEF;

  typedef enum logic [1:0] {
    HUNT_DLE,
    HUNT_STX,
    IN_FRAME,
    IN_FRAME_ESC
  } hunt_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Deframer model state
  hunt_t       hunt_st   = HUNT_DLE;
  int unsigned frame_len = 0;
  bit          held_buf  = 1'b0;

  out_t        pending_results[$];
  int unsigned err_cnt     = 0;
  int unsigned sent_cnt    = 0;
  longint      cycle_cnt   = 0;
  longint      hold_until  = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  dle_stx_etx_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Drive result-side ready: hold off during a long stall, else random idling
  always @(posedge clk) begin
    if (cycle_cnt < hold_until) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  task automatic push_event(input event_t ev, input logic [7:0] ch, input int unsigned pos);
    out_t r;
    r.event_res  = ev;
    r.char_value = ch;
    r.position   = POS_W'(pos);
    pending_results.push_back(r);
  endtask

  // Store one payload character, or discard the frame when it is full
  task automatic store_payload(input logic [7:0] ch);
    if (frame_len >= MAX_LEN) begin
      hunt_st   = HUNT_DLE;
      frame_len = 0;
      held_buf  = 1'b0;
      push_event(EV_OVERFLOW, 8'h00, MAX_LEN);
    end else begin
      push_event(EV_CHAR, ch, frame_len);
      frame_len++;
    end
  endtask

  task automatic deframe_char(input in_t d);
    case (hunt_st)
      HUNT_DLE: begin
        if (d.rx_char == CH_DLE) hunt_st = HUNT_STX;
      end
      HUNT_STX: begin
        if (d.rx_char != CH_STX) begin
          hunt_st = HUNT_DLE;
        end else begin
          if (!held_buf) held_buf = d.buffer_ready;
          if (held_buf) begin
            frame_len = 0;
            hunt_st   = IN_FRAME;
          end else begin
            hunt_st = HUNT_DLE;
            push_event(EV_NOBUF, 8'h00, 0);
          end
        end
      end
      IN_FRAME: begin
        if (d.rx_char == CH_DLE) hunt_st = IN_FRAME_ESC;
        else store_payload(d.rx_char);
      end
      default: begin
        hunt_st = IN_FRAME;
        if (d.rx_char == CH_DLE) begin
          store_payload(d.rx_char);
        end else if (d.rx_char == CH_STX) begin
          frame_len = 0;
          push_event(EV_RESTART, 8'h00, 0);
        end else begin
          hunt_st  = HUNT_DLE;
          held_buf = 1'b0;
          if (d.rx_char == CH_ETX) push_event(EV_DONE, 8'h00, frame_len);
          else push_event(EV_ABANDON, 8'h00, 0);
          frame_len = 0;
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic check_result(input out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result ev=%0d ch=%02h pos=%0d",
               $time, got.event_res, got.char_value, got.position);
      err_cnt++;
    end else begin
      want = pending_results.pop_front();
      if (got.event_res !== want.event_res) begin
        $display("%0t: event_res expected %0d actual %0d", $time,
                 want.event_res, got.event_res);
        err_cnt++;
      end
      if (got.char_value !== want.char_value) begin
        $display("%0t: char_value expected %02h actual %02h", $time,
                 want.char_value, got.char_value);
        err_cnt++;
      end
      if (got.position !== want.position) begin
        $display("%0t: position expected %0d actual %0d", $time,
                 want.position, got.position);
        err_cnt++;
      end
    end
  endtask

  // Check each result transfer, then predict each character transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) deframe_char(in_data);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic rdy);
    in_t item;
    item.rx_char      = c;
    item.buffer_ready = rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
  endtask

  // Send one payload byte, doubling a DLE
  task automatic send_payload(input logic [7:0] c);
    if (c == CH_DLE) send_char(CH_DLE, 1'($urandom_range(1)));
    send_char(c, 1'($urandom_range(1)));
  endtask

  task automatic open_frame(input logic rdy);
    send_char(CH_DLE, 1'($urandom_range(1)));
    send_char(CH_STX, rdy);
  endtask

  task automatic close_frame();
    send_char(CH_DLE, 1'($urandom_range(1)));
    send_char(CH_ETX, 1'($urandom_range(1)));
  endtask

  // Pause the sender until every predicted result has been taken
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_char();
    case ($urandom_range(7))
      0:       return CH_DLE;
      1:       return CH_STX;
      2:       return CH_ETX;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One random frame: mostly well formed, sometimes broken or plain noise
  task automatic send_random_frame();
    int unsigned n;
    int unsigned pick;
    logic [7:0]  c;
    if ($urandom_range(99) < 85) begin
      open_frame(1'($urandom_range(9) != 0));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) send_char(rand_char(), 1'($urandom_range(1)));
    end
    n = ($urandom_range(19) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
    repeat (n) begin
      if ($urandom_range(99) < 3) begin
        // broken escape inside the frame
        send_char(CH_DLE, 1'($urandom_range(1)));
        send_char(rand_char(), 1'($urandom_range(1)));
      end else begin
        send_payload(rand_char());
      end
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      close_frame();
    end else if (pick < 80) begin
      open_frame(1'($urandom_range(1)));
      n = $urandom_range(0, 6);
      repeat (n) send_payload(rand_char());
      close_frame();
    end else if (pick < 90) begin
      send_char(CH_DLE, 1'($urandom_range(1)));
      do c = 8'($urandom_range(255));
      while (c == CH_DLE || c == CH_STX || c == CH_ETX);
      send_char(c, 1'($urandom_range(1)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    // noise while hunting, DLE then a non-STX
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(CH_DLE, 1'b0);
    send_char(8'h41, 1'b1);
    // no buffer at frame start
    open_frame(1'b0);
    // payload extremes, doubled DLE, restart, done
    open_frame(1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_payload(CH_DLE);
    send_char(CH_DLE, 1'b1);
    send_char(CH_STX, 1'b0);
    send_char(8'hA5, 1'b0);
    close_frame();
    // empty frame
    open_frame(1'b1);
    close_frame();
    // bad DLE sequence
    open_frame(1'b1);
    send_char(8'h5A, 1'b1);
    send_char(CH_DLE, 1'b0);
    send_char(8'h7E, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_length_limit();
    send_idle_pct = 10;
    recv_idle_pct <= 10;
    // full frame closes normally
    open_frame(1'b1);
    repeat (MAX_LEN) send_payload(8'($urandom_range(255)));
    close_frame();
    // one character too many
    open_frame(1'b1);
    repeat (MAX_LEN) send_payload(8'($urandom_range(255)));
    send_char(8'h3C, 1'b1);
    send_char(8'h3D, 1'b0);
    // overflow on a doubled DLE
    open_frame(1'b1);
    repeat (MAX_LEN) send_payload(8'($urandom_range(255)));
    send_payload(CH_DLE);
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_until <= cycle_cnt + 300;
    open_frame(1'b1);
    repeat (40) send_payload(8'($urandom_range(255)));
    close_frame();
    wait_results_drained();
  endtask

  task automatic test_random(input int unsigned n_items, input int s_pct, input int r_pct);
    int unsigned start;
    start = sent_cnt;
    send_idle_pct = s_pct;
    recv_idle_pct <= r_pct;
    while (sent_cnt - start < n_items) send_random_frame();
    wait_results_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_length_limit();
    test_backpressure();
    test_random(165, 16, 48);
    test_random(165, 48, 16);
    test_random(165, 0, 0);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (pending_results.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule
